// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

  typedef enum logic [1:0] {
    ST_ROOTS   = 2'd0,
    ST_NO_REAL = 2'd1,
    ST_A_ZERO  = 2'd2
  } status_e;

  localparam int unsigned OutFrac = 16;
  localparam int unsigned OutW    = 32;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// Pipeline stages from input transfer to result:
//   magnitudes, products, discriminant, COEF_WIDTH+18 square root bit stages,
//   numerator, COEF_WIDTH+20 divider bit stages, saturation/output register.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Reset: rst_ni clears all valid bits; data registers are not reset.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COEF_WIDTH-1:0]   coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_c_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qrs_pkg::status_e               status_o,
  output logic signed [qrs_pkg::OutW-1:0] root_plus_o,
  output logic signed [qrs_pkg::OutW-1:0] root_minus_o
);
  import qrs_pkg::*;

  localparam int unsigned W    = COEF_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned DW   = 2 * W + 3;
  localparam int unsigned XW   = 2 * W + 36;
  localparam int unsigned RW   = W + 18;
  localparam int unsigned REMW = RW + 3;
  localparam int unsigned NW   = W + 20;
  localparam int unsigned DVW  = W + 1;

  typedef struct packed {
    status_e               status;
    logic signed [W-1:0]   b;
    logic                  a_neg;
    logic [W-1:0]          a_mag;
  } side_t;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: magnitudes
  logic         s1_vld_q;
  side_t        s1_side_q;
  logic [W-1:0] s1_bmag_q, s1_cmag_q;
  logic         s1_cneg_q;

  // stage 2: products
  logic          s2_vld_q;
  side_t         s2_side_q;
  logic [PW-1:0] s2_bb_q, s2_ac_q;
  logic          s2_same_q;

  // square root stages, index 0 is the discriminant stage
  logic              sq_vld_q  [RW+1];
  side_t             sq_side_q [RW+1];
  logic [XW-1:0]     sq_x_q    [RW+1];
  logic [REMW-1:0]   sq_rem_q  [RW+1];
  logic [RW-1:0]     sq_root_q [RW+1];

  // divider stages, index 0 is the numerator stage; lane 0 plus, lane 1 minus
  logic              dv_vld_q  [NW+1];
  side_t             dv_side_q [NW+1];
  logic [NW-1:0]     dv_num_q  [NW+1][2];
  logic [DVW-1:0]    dv_rem_q  [NW+1][2];
  logic [NW-1:0]     dv_quo_q  [NW+1][2];
  logic              dv_neg_q  [NW+1][2];

  logic                   out_vld_q;
  status_e                status_q;
  logic [OutW-1:0]        rp_q, rm_q;
  logic                   out_aneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      sq_vld_q[0] <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      sq_vld_q[0] <= s2_vld_q;
      dv_vld_q[0] <= sq_vld_q[RW];
      out_vld_q   <= dv_vld_q[NW];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q.status <= ST_ROOTS;
      s1_side_q.b      <= coef_b_i;
      s1_side_q.a_neg  <= coef_a_i[W-1];
      s1_side_q.a_mag  <= coef_a_i[W-1] ? (~coef_a_i + 1'b1) : coef_a_i;
      s1_bmag_q        <= coef_b_i[W-1] ? (~coef_b_i + 1'b1) : coef_b_i;
      s1_cmag_q        <= coef_c_i[W-1] ? (~coef_c_i + 1'b1) : coef_c_i;
      s1_cneg_q        <= coef_c_i[W-1];
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_bb_q   <= s1_bmag_q * s1_bmag_q;
      s2_ac_q   <= s1_side_q.a_mag * s1_cmag_q;
      s2_same_q <= (s1_cmag_q != '0) && (s1_side_q.a_neg == s1_cneg_q);
    end
  end

  // stage 3: discriminant and status
  logic [DW-1:0] bb_ext, ac4_ext, disc;
  side_t         s3_side;
  always_comb begin
    bb_ext  = DW'(s2_bb_q);
    ac4_ext = DW'({s2_ac_q, 2'b00});
    disc    = s2_same_q ? (bb_ext - ac4_ext) : (bb_ext + ac4_ext);
    s3_side = s2_side_q;
    if (s2_side_q.a_mag == '0) begin
      s3_side.status = ST_A_ZERO;
    end else if (s2_same_q && (bb_ext < ac4_ext)) begin
      s3_side.status = ST_NO_REAL;
    end else begin
      s3_side.status = ST_ROOTS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side_q[0] <= s3_side;
      sq_x_q[0]    <= {1'b0, disc, 32'd0};
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            ge;
    always_comb begin
      rem_sh = {sq_rem_q[k][REMW-3:0], sq_x_q[k][XW-1-2*k -: 2]};
      trial  = REMW'({sq_root_q[k], 2'b01});
      ge     = rem_sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_side_q[k+1] <= sq_side_q[k];
        sq_x_q[k+1]    <= sq_x_q[k];
        sq_rem_q[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_q[k+1] <= {sq_root_q[k][RW-2:0], ge};
      end
    end
  end

  // numerator stage
  logic signed [NW-1:0] b_ext, nb, s_ext, np, nm;
  logic [NW-1:0]        mp, mm;
  always_comb begin
    b_ext = NW'(sq_side_q[RW].b);
    nb    = -(b_ext <<< OutFrac);
    s_ext = $signed(NW'(sq_root_q[RW]));
    np    = nb + s_ext;
    nm    = nb - s_ext;
    mp    = np[NW-1] ? NW'(-np) : NW'(np);
    mm    = nm[NW-1] ? NW'(-nm) : NW'(nm);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0]   <= sq_side_q[RW];
      dv_num_q[0][0] <= mp + NW'(sq_side_q[RW].a_mag);
      dv_num_q[0][1] <= mm + NW'(sq_side_q[RW].a_mag);
      dv_neg_q[0][0] <= np[NW-1] ^ sq_side_q[RW].a_neg;
      dv_neg_q[0][1] <= nm[NW-1] ^ sq_side_q[RW].a_neg;
      dv_rem_q[0][0] <= '0;
      dv_rem_q[0][1] <= '0;
      dv_quo_q[0][0] <= '0;
      dv_quo_q[0][1] <= '0;
    end
  end

  // restoring divide by 2|a|, one quotient bit per stage
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DVW-1:0] dd;
    assign dd = {dv_side_q[j].a_mag, 1'b0};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVW:0] rem_sh;
      logic         ge;
      always_comb begin
        rem_sh = {dv_rem_q[j][l], dv_num_q[j][l][NW-1-j]};
        ge     = rem_sh >= (DVW+1)'(dd);
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_num_q[j+1][l] <= dv_num_q[j][l];
          dv_neg_q[j+1][l] <= dv_neg_q[j][l];
          dv_rem_q[j+1][l] <= ge ? DVW'(rem_sh - (DVW+1)'(dd)) : DVW'(rem_sh);
          dv_quo_q[j+1][l] <= {dv_quo_q[j][l][NW-2:0], ge};
        end
      end
    end
  end

  function automatic logic [OutW-1:0] sat_fn(logic [NW-1:0] q, logic neg);
    logic [63:0] q64;
    logic [63:0] neg_q;
    q64   = 64'(q);
    neg_q = -q64;
    if (neg) begin
      return (q64 > 64'h8000_0000) ? 32'h8000_0000 : neg_q[OutW-1:0];
    end else begin
      return (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[OutW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q   <= dv_side_q[NW].status;
      out_aneg_q <= dv_side_q[NW].a_neg;
      if (dv_side_q[NW].status == ST_ROOTS) begin
        rp_q <= sat_fn(dv_quo_q[NW][0], dv_neg_q[NW][0]);
        rm_q <= sat_fn(dv_quo_q[NW][1], dv_neg_q[NW][1]);
      end else begin
        rp_q <= '0;
        rm_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = status_q;
  assign root_plus_o  = $signed(rp_q);
  assign root_minus_o = $signed(rm_q);

  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ROOTS) |-> (rp_q == '0) && (rm_q == '0))
    else $error("roots nonzero without real roots");

  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ROOTS) && !out_aneg_q |-> root_plus_o >= root_minus_o)
    else $error("root order wrong for positive a");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[0] && (sq_side_q[0].a_mag == '0) |-> sq_side_q[0].status == ST_A_ZERO)
    else $error("zero a not flagged");

endmodule
